// ----- hdl/psf_pkg.sv -----
// ============================================================================
// psf_pkg
// Shared types, widths, register codes and the exp constant table of the
// pinning site force unit.
// ============================================================================
package psf_pkg;

    localparam int POS_W      = 24;   // offset width, signed Q12.12
    localparam int LEN_W      = 23;   // radius, line length, decay length
    localparam int STR_W      = 24;   // strength, Q8.16
    localparam int FORCE_W    = 32;   // force component, Q16.16
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DIST_W     = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam int XQ_W       = 21;   // exponent argument, Q5.16
    localparam int EXP_STAGES = XQ_W;
    localparam int WQ_W       = 32;   // exp value, Q0.32
    localparam int DEN_W      = WQ_W + 2;
    localparam int SQ_W       = WQ_W - 1;   // r and s quotients
    localparam int MAG_W      = 24;   // force magnitude, below 2^24

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHAPE  = 3'd0,
        REG_RADIUS = 3'd1,
        REG_LINE   = 3'd2,
        REG_STR    = 3'd3,
        REG_DECAY  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] offset_x;
        logic signed [POS_W-1:0] offset_y;
    } psf_in_t;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic                      saturated;
    } psf_out_t;

    typedef logic [EXP_STAGES-1:0][WQ_W-1:0] exp_tab_t;

    // e^-(2^-k) in Q0.32: series summed in Q0.60 with truncated terms
    function automatic logic [WQ_W-1:0] exp_frac_const(input int k);
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] rnd;
        term = 64'd1 << 60;
        sum  = 64'd1 << 60;
        for (int n = 1; n < 64; n++) begin
            if (term != 64'd0) begin
                term = (term >> k) / 64'(n);
                if ((n % 2) == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
        end
        rnd = (sum + (64'd1 << 27)) >> 28;
        return rnd[WQ_W-1:0];
    endfunction

    function automatic logic [WQ_W-1:0] mul_q32(input logic [WQ_W-1:0] a,
                                                input logic [WQ_W-1:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b) + (64'd1 << 31);
        return p[63:32];
    endfunction

    // integer bits 0..4 first, then fraction bits from low to high
    function automatic exp_tab_t exp_table();
        exp_tab_t          t;
        logic [WQ_W-1:0]   c;
        c = exp_frac_const(0);
        for (int j = 0; j < 5; j++) begin
            t[j] = c;
            c    = mul_q32(c, c);
        end
        for (int b = 0; b < 16; b++)
            t[5 + b] = exp_frac_const(16 - b);
        return t;
    endfunction

    localparam exp_tab_t EXP_C = exp_table();

endpackage

// ----- hdl/psf_isqrt.sv -----
// ============================================================================
// psf_isqrt
// Pipelined floor square root, one result bit per stage.
// ============================================================================
module psf_isqrt
    import psf_pkg::*;
#(
    parameter int IW = 48,
    parameter int SW = 1
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [IW-1:0]   in_rad,
    input  logic [SW-1:0]   in_side,
    output logic            out_valid,
    output logic [IW/2-1:0] out_root,
    output logic [SW-1:0]   out_side
);

    localparam int N = IW / 2;

    logic          vld_reg  [N];
    logic [IW-1:0] v_reg    [N];
    logic [IW-1:0] r_reg    [N];
    logic [SW-1:0] side_reg [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        localparam logic [IW-1:0] BIT = IW'(1) << (IW - 2 - 2 * s);
        logic          src_vld;
        logic [IW-1:0] src_v;
        logic [IW-1:0] src_r;
        logic [SW-1:0] src_side;
        logic [IW-1:0] trial;
        logic          ge;
        logic [IW-1:0] v_next;
        logic [IW-1:0] r_next;

        if (s == 0) begin : g_first
            assign src_vld  = in_valid;
            assign src_v    = in_rad;
            assign src_r    = '0;
            assign src_side = in_side;
        end
        else begin : g_next
            assign src_vld  = vld_reg[s-1];
            assign src_v    = v_reg[s-1];
            assign src_r    = r_reg[s-1];
            assign src_side = side_reg[s-1];
        end

        always_comb
        begin
            trial  = src_r + BIT;
            ge     = (src_v >= trial);
            v_next = ge ? (src_v - trial) : src_v;
            r_next = ge ? ((src_r >> 1) + BIT) : (src_r >> 1);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else
                vld_reg[s] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            v_reg[s]    <= v_next;
            r_reg[s]    <= r_next;
            side_reg[s] <= src_side;
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_root  = r_reg[N-1][N-1:0];
    assign out_side  = side_reg[N-1];

endmodule

// ----- hdl/psf_div.sv -----
// ============================================================================
// psf_div
// Pipelined restoring divider, one quotient bit per stage. The caller gives
// a starting remainder below the divisor and the dividend bits to shift in.
// ============================================================================
module psf_div
    import psf_pkg::*;
#(
    parameter int DVW = 23,
    parameter int QW  = 21,
    parameter int SW  = 1
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [DVW-1:0] in_rem,
    input  logic [QW-1:0]  in_bits,
    input  logic [DVW-1:0] in_dv,
    input  logic [SW-1:0]  in_side,
    output logic           out_valid,
    output logic [QW-1:0]  out_q,
    output logic [SW-1:0]  out_side
);

    logic           vld_reg  [QW];
    logic [DVW-1:0] rem_reg  [QW];
    logic [QW-1:0]  bits_reg [QW];
    logic [DVW-1:0] dv_reg   [QW];
    logic [SW-1:0]  side_reg [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic           src_vld;
        logic [DVW-1:0] src_rem;
        logic [QW-1:0]  src_bits;
        logic [DVW-1:0] src_dv;
        logic [SW-1:0]  src_side;
        logic [DVW:0]   trial;
        logic [DVW:0]   diff;
        logic           ge;
        logic [DVW-1:0] rem_next;
        logic [QW-1:0]  bits_next;

        if (s == 0) begin : g_first
            assign src_vld  = in_valid;
            assign src_rem  = in_rem;
            assign src_bits = in_bits;
            assign src_dv   = in_dv;
            assign src_side = in_side;
        end
        else begin : g_next
            assign src_vld  = vld_reg[s-1];
            assign src_rem  = rem_reg[s-1];
            assign src_bits = bits_reg[s-1];
            assign src_dv   = dv_reg[s-1];
            assign src_side = side_reg[s-1];
        end

        // shift the quotient bit in where the dividend bit leaves
        always_comb
        begin
            trial     = {src_rem, src_bits[QW-1]};
            diff      = trial - {1'b0, src_dv};
            ge        = (trial >= {1'b0, src_dv});
            rem_next  = ge ? diff[DVW-1:0] : trial[DVW-1:0];
            bits_next = {src_bits[QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else
                vld_reg[s] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= rem_next;
            bits_reg[s] <= bits_next;
            dv_reg[s]   <= src_dv;
            side_reg[s] <= src_side;
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_q     = bits_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

// ----- hdl/psf_exp.sv -----
// ============================================================================
// psf_exp
// Pipelined e^-x, Q1.32 out (Q0.32 inside): one rounded constant multiply per argument bit.
// ============================================================================
module psf_exp
    import psf_pkg::*;
#(
    parameter int SW = 1
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [XQ_W-1:0] in_x,
    input  logic            in_zero,
    input  logic [SW-1:0]   in_side,
    output logic            out_valid,
    output logic [WQ_W:0]   out_w,
    output logic [SW-1:0]   out_side
);

    logic            vld_reg  [EXP_STAGES];
    logic [XQ_W-1:0] x_reg    [EXP_STAGES];
    logic            one_reg  [EXP_STAGES];
    logic            zero_reg [EXP_STAGES];
    logic [WQ_W-1:0] w_reg    [EXP_STAGES];
    logic [SW-1:0]   side_reg [EXP_STAGES];

    for (genvar s = 0; s < EXP_STAGES; s++) begin : g_stage
        localparam int XB = (s < 5) ? (16 + s) : (s - 5);
        logic            src_vld;
        logic [XQ_W-1:0] src_x;
        logic            src_one;
        logic            src_zero;
        logic [WQ_W-1:0] src_w;
        logic [SW-1:0]   src_side;
        logic            bit_on;
        logic [63:0]     prod;
        logic [63:0]     rounded;
        logic [WQ_W-1:0] w_next;
        logic            one_next;

        if (s == 0) begin : g_first
            assign src_vld  = in_valid;
            assign src_x    = in_x;
            assign src_one  = 1'b1;
            assign src_zero = in_zero;
            assign src_w    = '0;
            assign src_side = in_side;
        end
        else begin : g_next
            assign src_vld  = vld_reg[s-1];
            assign src_x    = x_reg[s-1];
            assign src_one  = one_reg[s-1];
            assign src_zero = zero_reg[s-1];
            assign src_w    = w_reg[s-1];
            assign src_side = side_reg[s-1];
        end

        // w still exactly one: the product is the constant itself
        always_comb
        begin
            bit_on   = src_x[XB];
            prod     = 64'(src_w) * 64'(EXP_C[s]);
            rounded  = prod + (64'd1 << 31);
            w_next   = bit_on ? (src_one ? EXP_C[s] : rounded[63:32]) : src_w;
            one_next = src_one & ~bit_on;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else
                vld_reg[s] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            x_reg[s]    <= src_x;
            one_reg[s]  <= one_next;
            zero_reg[s] <= src_zero;
            w_reg[s]    <= w_next;
            side_reg[s] <= src_side;
        end
    end

    assign out_valid = vld_reg[EXP_STAGES-1];
    assign out_side  = side_reg[EXP_STAGES-1];

    always_comb
    begin
        if (zero_reg[EXP_STAGES-1])
            out_w = '0;
        else if (one_reg[EXP_STAGES-1])
            out_w = {1'b1, {WQ_W{1'b0}}};
        else
            out_w = {1'b0, w_reg[EXP_STAGES-1]};
    end

endmodule

// ----- hdl/pinning_site_force_unit.sv -----
// ============================================================================
// pinning_site_force_unit
// Pinning force of one circle or line site on one vortex offset.
// ============================================================================
// Use:
//   Raise start with an offset on item; it is taken at any edge where start
//   is high and busy low. busy stays low: a new request may enter every
//   cycle, so one force per cycle is sustained.
//   Each result appears on result for one cycle with done high, in request
//   order. The receiver cannot hold results off and the pipeline never
//   stalls. The pipeline is a chain of bit-per-stage units: two square
//   roots side by side (24 stages), the distance/decay divide (21), the
//   exp multiplier chain (21), the two sech divides (31 each), the force
//   divides (24), plus seven register stages around them.
//   Registers are written over cfg_valid/cfg_ready/cfg_index/cfg_data; the
//   user must do so only while no request is in flight, as the block does
//   not enforce it. cfg_ready is always high and unknown indexes are dropped.
//   Reset clears the pipeline valid bits and loads the register defaults
//   (circle, zero radius, zero length, zero strength, decay length 1.0).
// ============================================================================
module pinning_site_force_unit
    import psf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  psf_in_t               item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output psf_out_t              result
);

    localparam int SQR_W  = 2 * POS_W;
    localparam int LD_W   = 2 + 2 * POS_W;        // posx, posy, ax, ay
    localparam int S4_W   = 2 + 3 * POS_W;        // plus nd
    localparam int PRD_W  = MAG_W + POS_W;
    localparam int FDV_W  = POS_W + 1;
    localparam int MUL_W  = STR_W + SQ_W;

    // ---------------- configuration
    logic             shape_reg;
    logic [LEN_W-1:0] radius_reg;
    logic [LEN_W-1:0] line_reg;
    logic [STR_W-1:0] strength_reg;
    logic [LEN_W-1:0] decay_reg;
    logic [LEN_W-1:0] lpv;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            shape_reg    <= 1'b0;
            radius_reg   <= '0;
            line_reg     <= '0;
            strength_reg <= '0;
            decay_reg    <= LEN_W'(4096);
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SHAPE:  shape_reg    <= cfg_data[0];
                REG_RADIUS: radius_reg   <= cfg_data[LEN_W-1:0];
                REG_LINE:   line_reg     <= cfg_data[LEN_W-1:0];
                REG_STR:    strength_reg <= cfg_data[STR_W-1:0];
                REG_DECAY:  decay_reg    <= cfg_data[LEN_W-1:0];
                default:    ;
            endcase
        end
    end

    // a zero decay length acts as one LSB
    assign lpv = (decay_reg == '0) ? LEN_W'(1) : decay_reg;

    // ---------------- stage 1: magnitudes and line-end offset
    logic             s1_valid_reg;
    logic [POS_W-1:0] s1_ax_reg, s1_ay_reg, s1_ex_reg;
    logic             s1_posx_reg, s1_posy_reg, s1_seg_reg;
    logic [POS_W-1:0] ax_next, ay_next, ex_next;
    logic             seg_next;

    always_comb
    begin
        ax_next  = item.offset_x[POS_W-1] ? POS_W'(-item.offset_x) : item.offset_x;
        ay_next  = item.offset_y[POS_W-1] ? POS_W'(-item.offset_y) : item.offset_y;
        seg_next = ({1'b0, ax_next, 1'b0} <= (POS_W + 2)'(line_reg));
        ex_next  = seg_next ? '0 : (ax_next - POS_W'(line_reg >> 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        s1_ax_reg   <= ax_next;
        s1_ay_reg   <= ay_next;
        s1_ex_reg   <= ex_next;
        s1_posx_reg <= ~item.offset_x[POS_W-1] & (item.offset_x != '0);
        s1_posy_reg <= ~item.offset_y[POS_W-1] & (item.offset_y != '0);
        s1_seg_reg  <= seg_next;
    end

    // ---------------- stage 2: squares
    logic             s2_valid_reg;
    logic [SQR_W-1:0] s2_sqx_reg, s2_sqy_reg, s2_sqe_reg;
    logic [POS_W-1:0] s2_ax_reg, s2_ay_reg;
    logic             s2_posx_reg, s2_posy_reg, s2_seg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_sqx_reg  <= SQR_W'(s1_ax_reg) * SQR_W'(s1_ax_reg);
        s2_sqy_reg  <= SQR_W'(s1_ay_reg) * SQR_W'(s1_ay_reg);
        s2_sqe_reg  <= SQR_W'(s1_ex_reg) * SQR_W'(s1_ex_reg);
        s2_ax_reg   <= s1_ax_reg;
        s2_ay_reg   <= s1_ay_reg;
        s2_posx_reg <= s1_posx_reg;
        s2_posy_reg <= s1_posy_reg;
        s2_seg_reg  <= s1_seg_reg;
    end

    // ---------------- stage 3: sums of squares
    logic             s3_valid_reg;
    logic [SQR_W-1:0] s3_sumd_reg, s3_sume_reg;
    logic [LD_W-1:0]  s3_side_reg;
    logic             s3_seg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_sumd_reg <= s2_sqx_reg + s2_sqy_reg;
        s3_sume_reg <= s2_sqe_reg + s2_sqy_reg;
        s3_side_reg <= {s2_posx_reg, s2_posy_reg, s2_ax_reg, s2_ay_reg};
        s3_seg_reg  <= s2_seg_reg;
    end

    // ---------------- square roots: |d| and distance to the line end
    logic             rd_valid;
    logic [POS_W-1:0] rd_root, re_root;
    logic [LD_W-1:0]  rd_side;
    logic             re_seg;

    psf_isqrt #(.IW(SQR_W), .SW(LD_W)) u_sqrt_d (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_rad    (s3_sumd_reg),
        .in_side   (s3_side_reg),
        .out_valid (rd_valid),
        .out_root  (rd_root),
        .out_side  (rd_side)
    );

    psf_isqrt #(.IW(SQR_W), .SW(1)) u_sqrt_e (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_rad    (s3_sume_reg),
        .in_side   (s3_seg_reg),
        .out_valid (),
        .out_root  (re_root),
        .out_side  (re_seg)
    );

    // ---------------- stage 4: site distance
    logic              s4_valid_reg;
    logic [DIST_W-1:0] s4_dist_reg;
    logic              s4_ovf_reg;
    logic [S4_W-1:0]   s4_side_reg;
    logic [DIST_W-1:0] dist_next;
    logic [DIST_W-1:0] nd_ext, rad_ext;
    logic [POS_W-1:0]  rd_ay;

    assign rd_ay   = rd_side[POS_W-1:0];
    assign nd_ext  = DIST_W'(rd_root);
    assign rad_ext = DIST_W'(radius_reg);

    always_comb
    begin
        if (!shape_reg)
            dist_next = (nd_ext >= rad_ext) ? (nd_ext - rad_ext) : (rad_ext - nd_ext);
        else if (re_seg)
            dist_next = DIST_W'(rd_ay);
        else
            dist_next = DIST_W'(re_root);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= rd_valid;
    end

    // exp argument of 32 or more gives zero
    always_ff @(posedge clk)
    begin
        s4_dist_reg <= dist_next;
        s4_ovf_reg  <= ((DIST_W + 4)'(dist_next) >= (DIST_W + 4)'({lpv, 4'b0000}));
        s4_side_reg <= {rd_side, rd_root};
    end

    // ---------------- x = 2 * dist / lp in Q.16
    logic             dx_valid;
    logic [XQ_W-1:0]  dx_q;
    logic [S4_W:0]    dx_side;
    logic [LEN_W-1:0] dx_rem;

    assign dx_rem = s4_ovf_reg ? '0 : LEN_W'(s4_dist_reg >> 4);

    psf_div #(.DVW(LEN_W), .QW(XQ_W), .SW(S4_W + 1)) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .in_rem    (dx_rem),
        .in_bits   ({s4_dist_reg[3:0], 17'b0}),
        .in_dv     (lpv),
        .in_side   ({s4_ovf_reg, s4_side_reg}),
        .out_valid (dx_valid),
        .out_q     (dx_q),
        .out_side  (dx_side)
    );

    // ---------------- w = e^-x
    logic            ex_valid;
    logic [WQ_W:0]   ex_w;
    logic [S4_W-1:0] ex_side;
    logic [DEN_W-1:0] den;

    psf_exp #(.SW(S4_W)) u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dx_valid),
        .in_x      (dx_q),
        .in_zero   (dx_side[S4_W]),
        .in_side   (dx_side[S4_W-1:0]),
        .out_valid (ex_valid),
        .out_w     (ex_w),
        .out_side  (ex_side)
    );

    assign den = (DEN_W'(1) << WQ_W) + DEN_W'(ex_w);

    // ---------------- r = w * 2^31 / (2^32 + w)
    logic                  dr_valid;
    logic [SQ_W-1:0]       dr_q;
    logic [DEN_W+S4_W-1:0] dr_side;

    psf_div #(.DVW(DEN_W), .QW(SQ_W), .SW(DEN_W + S4_W)) u_div_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ex_valid),
        .in_rem    (DEN_W'(ex_w)),
        .in_bits   ('0),
        .in_dv     (den),
        .in_side   ({den, ex_side}),
        .out_valid (dr_valid),
        .out_q     (dr_q),
        .out_side  (dr_side)
    );

    // ---------------- s = r * 2^33 / (2^32 + w), sech^2 in Q0.30
    logic            ds_valid;
    logic [SQ_W-1:0] ds_q;
    logic [S4_W-1:0] ds_side;

    psf_div #(.DVW(DEN_W), .QW(SQ_W), .SW(S4_W)) u_div_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dr_valid),
        .in_rem    (DEN_W'({dr_q, 2'b00})),
        .in_bits   ('0),
        .in_dv     (dr_side[DEN_W+S4_W-1:S4_W]),
        .in_side   (dr_side[S4_W-1:0]),
        .out_valid (ds_valid),
        .out_q     (ds_q),
        .out_side  (ds_side)
    );

    // ---------------- stage 5: magnitude m = kp * s / 2^30
    logic             s5_valid_reg;
    logic [MAG_W-1:0] s5_m_reg;
    logic [S4_W-1:0]  s5_side_reg;
    logic [MUL_W-1:0] kp_prod;

    assign kp_prod = MUL_W'(strength_reg) * MUL_W'(ds_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else
            s5_valid_reg <= ds_valid;
    end

    always_ff @(posedge clk)
    begin
        s5_m_reg    <= kp_prod[30 +: MAG_W];
        s5_side_reg <= ds_side;
    end

    // ---------------- stage 6: m * |d_c| and |d| + 1
    logic             s6_valid_reg;
    logic [PRD_W-1:0] s6_prodx_reg, s6_prody_reg;
    logic [FDV_W-1:0] s6_dvsr_reg;
    logic             s6_posx_reg, s6_posy_reg;
    logic             s5_posx, s5_posy;
    logic [POS_W-1:0] s5_ax, s5_ay, s5_nd;

    assign {s5_posx, s5_posy, s5_ax, s5_ay, s5_nd} = s5_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s6_prodx_reg <= PRD_W'(s5_m_reg) * PRD_W'(s5_ax);
        s6_prody_reg <= PRD_W'(s5_m_reg) * PRD_W'(s5_ay);
        s6_dvsr_reg  <= FDV_W'(s5_nd) + FDV_W'(1);
        s6_posx_reg  <= s5_posx;
        s6_posy_reg  <= s5_posy;
    end

    // ---------------- per-component magnitude m * |d_c| / (|d| + 1)
    logic             fx_valid;
    logic [MAG_W-1:0] fx_mag, fy_mag;
    logic             fx_pos, fy_pos;

    psf_div #(.DVW(FDV_W), .QW(MAG_W), .SW(1)) u_div_fx (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s6_valid_reg),
        .in_rem    (FDV_W'(s6_prodx_reg[PRD_W-1:MAG_W])),
        .in_bits   (s6_prodx_reg[MAG_W-1:0]),
        .in_dv     (s6_dvsr_reg),
        .in_side   (s6_posx_reg),
        .out_valid (fx_valid),
        .out_q     (fx_mag),
        .out_side  (fx_pos)
    );

    psf_div #(.DVW(FDV_W), .QW(MAG_W), .SW(1)) u_div_fy (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s6_valid_reg),
        .in_rem    (FDV_W'(s6_prody_reg[PRD_W-1:MAG_W])),
        .in_bits   (s6_prody_reg[MAG_W-1:0]),
        .in_dv     (s6_dvsr_reg),
        .in_side   (s6_posy_reg),
        .out_valid (),
        .out_q     (fy_mag),
        .out_side  (fy_pos)
    );

    // ---------------- stage 7: sign, clip and output register
    logic               done_reg;
    psf_out_t           result_reg;
    logic [FORCE_W:0]   magx_ext, magy_ext;
    logic [FORCE_W:0]   limx, limy;
    logic               clipx, clipy;
    logic [FORCE_W-1:0] fx_abs, fy_abs;

    // a positive offset pushes back, down to -2^31; otherwise up to 2^31-1
    always_comb
    begin
        magx_ext = (FORCE_W + 1)'(fx_mag);
        magy_ext = (FORCE_W + 1)'(fy_mag);
        limx     = fx_pos ? ((FORCE_W + 1)'(1) << (FORCE_W - 1))
                          : (((FORCE_W + 1)'(1) << (FORCE_W - 1)) - (FORCE_W + 1)'(1));
        limy     = fy_pos ? ((FORCE_W + 1)'(1) << (FORCE_W - 1))
                          : (((FORCE_W + 1)'(1) << (FORCE_W - 1)) - (FORCE_W + 1)'(1));
        clipx    = (magx_ext > limx);
        clipy    = (magy_ext > limy);
        fx_abs   = clipx ? limx[FORCE_W-1:0] : magx_ext[FORCE_W-1:0];
        fy_abs   = clipy ? limy[FORCE_W-1:0] : magy_ext[FORCE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= fx_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg.force_x   <= fx_pos ? -fx_abs : fx_abs;
        result_reg.force_y   <= fy_pos ? -fy_abs : fy_abs;
        result_reg.saturated <= clipx | clipy;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
